// ===== rtl/core/sfcrc_pkg.sv =====
package sfcrc_pkg;

  localparam int unsigned FrameChannels  = 4;
  localparam int unsigned FrameDataBytes = 2 * FrameChannels;
  localparam int unsigned FrameBytes     = FrameDataBytes + 2;
  localparam int unsigned FrameIdxW      = $clog2(FrameBytes);
  localparam int unsigned ByteW          = 8;
  localparam int unsigned CrcW           = 16;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  localparam logic [FrameIdxW-1:0] LastIdx = FrameIdxW'(FrameBytes - 1);

  typedef struct packed {
    logic signed [15:0] channel0;
    logic signed [15:0] channel1;
    logic signed [15:0] channel2;
    logic signed [15:0] channel3;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             last_byte;
  } out_word_t;

  typedef logic [FrameDataBytes-1:0][ByteW-1:0] data_bytes_t;

  // one slot of the crc pipeline
  typedef struct packed {
    logic             valid;
    data_bytes_t      data;
    logic [CrcW-1:0]  crc;
  } crc_slot_t;

endpackage

// ===== rtl/core/sfcrc_stage.sv =====
module sfcrc_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sfcrc_pkg::crc_slot_t    slot_i,
  input  logic [sfcrc_pkg::ByteW-1:0] byte_i,
  output sfcrc_pkg::crc_slot_t    slot_o
);

  // one byte of crc-16, lsb first, eight shift steps
  function automatic logic [sfcrc_pkg::CrcW-1:0] crc_byte(
    input logic [sfcrc_pkg::CrcW-1:0]  crc_in,
    input logic [sfcrc_pkg::ByteW-1:0] b
  );
    logic [sfcrc_pkg::CrcW-1:0] c;
    c = crc_in ^ {{(sfcrc_pkg::CrcW - sfcrc_pkg::ByteW){1'b0}}, b};
    for (int k = 0; k < sfcrc_pkg::ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ sfcrc_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic                       valid_q;
  sfcrc_pkg::data_bytes_t     data_q;
  logic [sfcrc_pkg::CrcW-1:0] crc_q, crc_d;

  assign crc_d = crc_byte(slot_i.crc, byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_i.valid) begin
      data_q <= slot_i.data;
      crc_q  <= crc_d;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.data  = data_q;
  assign slot_o.crc   = crc_q;

endmodule

// ===== rtl/core/sfcrc_serializer.sv =====
module sfcrc_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfcrc_pkg::crc_slot_t      slot_i,
  output logic                      result_valid_o,
  output sfcrc_pkg::out_word_t      result_o
);

  logic [sfcrc_pkg::FrameBytes-1:0][sfcrc_pkg::ByteW-1:0] frame_q;
  logic [sfcrc_pkg::FrameIdxW-1:0] idx_q, idx_d;
  logic                            active_q, active_d;
  logic                            valid_q, valid_d;
  sfcrc_pkg::out_word_t            word_q, word_d;

  always_comb begin
    idx_d    = idx_q;
    active_d = active_q;
    valid_d  = 1'b0;
    word_d   = word_q;
    if (active_q) begin
      valid_d           = 1'b1;
      word_d.frame_byte = frame_q[idx_q];
      word_d.last_byte  = (idx_q == sfcrc_pkg::LastIdx);
      idx_d             = idx_q + 1'b1;
      if (idx_q == sfcrc_pkg::LastIdx) begin
        active_d = 1'b0;
      end
    end
    // a new frame may land on the cycle the previous one sends its last byte
    if (slot_i.valid) begin
      idx_d    = '0;
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (slot_i.valid) begin
      frame_q <= {slot_i.crc, slot_i.data};
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = word_q;

endmodule

// ===== rtl/core/scope_frame_crc16_encoder.sv =====
// scope frame encoder with crc-16/modbus trailer
//
// input channel: a word of four signed 16-bit channels is taken at a rising
// edge where start_i is high and busy_o is low
// output channel: ten bytes per input word, one per cycle, each shown for one
// cycle with result_valid_o high; channel0..channel3 low byte then high byte,
// then crc low and crc high, last_byte set on the crc high byte
// the first byte leaves the serializer's output register once the word has
// passed the last crc stage; busy_o rises after an accept and stays up until
// the spacing counter runs out, so the serializer, driving one byte per cycle,
// never sees frames overlap; the crc runs through an 8-stage pipeline, one data
// byte per stage, and bytes leave back to back, with no gap at full rate
// reset: clears all valid bits, the busy counter and the serializer; no word
// is in flight after reset
// the receiver cannot stall, so the result strobe is never held off
module scope_frame_crc16_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  sfcrc_pkg::in_word_t   word_i,
  output logic                  result_valid_o,
  output sfcrc_pkg::out_word_t  result_o
);

  localparam int unsigned GapW = sfcrc_pkg::FrameIdxW;
  localparam logic [GapW-1:0] GapLoad = GapW'(sfcrc_pkg::FrameBytes - 1);

  logic            accept;
  logic [GapW-1:0] gap_q, gap_d;

  // pipeline slots: slot[0] is the entry, slot[k+1] leaves stage k
  sfcrc_pkg::crc_slot_t                         slot [sfcrc_pkg::FrameDataBytes+1];
  sfcrc_pkg::data_bytes_t                       in_bytes;
  logic [sfcrc_pkg::FrameDataBytes-1:0]         stage_valid;

  assign accept = start_i && !busy_o;

  // spacing counter holds busy_o high after each accept so frames never overlap
  always_comb begin
    gap_d = gap_q;
    if (accept) begin
      gap_d = GapLoad;
    end else if (gap_q != '0) begin
      gap_d = gap_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else begin
      gap_q <= gap_d;
    end
  end

  assign busy_o = (gap_q != '0);

  // frame data order: each channel low byte then high byte
  assign in_bytes[0] = word_i.channel0[7:0];
  assign in_bytes[1] = word_i.channel0[15:8];
  assign in_bytes[2] = word_i.channel1[7:0];
  assign in_bytes[3] = word_i.channel1[15:8];
  assign in_bytes[4] = word_i.channel2[7:0];
  assign in_bytes[5] = word_i.channel2[15:8];
  assign in_bytes[6] = word_i.channel3[7:0];
  assign in_bytes[7] = word_i.channel3[15:8];

  assign slot[0].valid = accept;
  assign slot[0].data  = in_bytes;
  assign slot[0].crc   = sfcrc_pkg::CrcInit;

  // stage k folds data byte k into the running crc
  for (genvar k = 0; k < sfcrc_pkg::FrameDataBytes; k++) begin : g_stage
    sfcrc_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .slot_i (slot[k]),
      .byte_i (slot[k].data[k]),
      .slot_o (slot[k+1])
    );
    assign stage_valid[k] = slot[k+1].valid;
  end

  // ten-byte frame out, one byte per cycle
  sfcrc_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .slot_i         (slot[sfcrc_pkg::FrameDataBytes]),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // words are spaced apart, so at most one is in the crc pipeline
  a_pipe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(stage_valid))
    else $error("more than one word in crc pipeline");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("busy not raised after accept");

  a_first_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##10 (result_valid_o && !result_o.last_byte))
    else $error("first frame byte missing");

  a_last_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##19 (result_valid_o && result_o.last_byte))
    else $error("last frame byte missing");

endmodule
